@@ rtl/core/pngds_pkg.sv @@
// Shared types and constants of the RGB565 downscaling frame store.
`default_nettype none

package pngds_pkg;

  // event codes
  localparam logic [2:0] FN_START  = 3'd0;
  localparam logic [2:0] FN_HEADER = 3'd1;
  localparam logic [2:0] FN_DRAW   = 3'd2;
  localparam logic [2:0] FN_END    = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  // configuration register indexes
  localparam logic CFG_EXP_WIDTH  = 1'b0;
  localparam logic CFG_EXP_HEIGHT = 1'b1;

  localparam logic [15:0] BG_COLOR       = 16'h1082;
  localparam logic [15:0] EXP_WIDTH_RST  = 16'd501;
  localparam logic [15:0] EXP_HEIGHT_RST = 16'd1002;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  src_x;
    logic [9:0]  src_y;
    logic [3:0]  rect_width;
    logic [3:0]  rect_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [13:0] read_address;
  } pngds_in_t;

  typedef struct packed {
    logic [15:0] read_color;
    logic        image_invalid;
    logic        image_done;
  } pngds_out_t;

  // rectangle handed to the span walker
  typedef struct packed {
    logic       start;
    logic [9:0] src_x;
    logic [9:0] src_y;
    logic [3:0] rect_width;
    logic [3:0] rect_height;
  } pngds_walk_req_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
    logic fin;
  } pngds_walk_st_t;

endpackage

`default_nettype wire

@@ rtl/core/pngds_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pngds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/pngds_walk.sv @@
// Span walker: maps a source rectangle onto target cells and issues writes.
`default_nettype none

module pngds_walk import pngds_pkg::*; #(
  parameter int SOURCE_SIZE = 500,
  parameter int TARGET_SIZE = 128
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire pngds_walk_req_t                          req,
  output pngds_walk_st_t                                st,
  output logic [$clog2(TARGET_SIZE*TARGET_SIZE)-1:0]    wr_addr
);

  localparam int DEPTH = TARGET_SIZE * TARGET_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(TARGET_SIZE + 1);
  localparam int PW    = $clog2((SOURCE_SIZE + 16) * TARGET_SIZE);
  localparam int K     = $clog2(SOURCE_SIZE * TARGET_SIZE);
  localparam int RECIP = (1 << K) / SOURCE_SIZE;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int RBW   = $clog2(DEPTH + 1);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_EST  = 2'd1;
  localparam logic [1:0] W_BASE = 2'd2;
  localparam logic [1:0] W_WALK = 2'd3;

  logic [1:0]     st_r, st_nxt;
  logic [PW-1:0]  xt_r, xe_r, yt_r, ye_r;   // scaled edges: coord*T
  logic [CW-1:0]  cest_r, c_r, r_r;
  logic [PW-1:0]  cs0_r, cs_r, rs_r;        // cell index * S
  logic [RBW-1:0] rb_r;                     // row * T

  logic [PW+RW-1:0] px, py;
  logic row_end, row_in, col_end, col_in;

  // estimate is floor(v*T/S) or one less; the walk skips cells before the span
  assign px = (PW+RW)'(xt_r) * (PW+RW)'(RECIP);
  assign py = (PW+RW)'(yt_r) * (PW+RW)'(RECIP);

  assign row_end = (rs_r >= ye_r) || (r_r >= CW'(TARGET_SIZE));
  assign row_in  = (rs_r >= yt_r);
  assign col_end = (cs_r >= xe_r) || (c_r >= CW'(TARGET_SIZE));
  assign col_in  = (cs_r >= xt_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      W_IDLE: if (req.start) st_nxt = W_EST;
      W_EST:  st_nxt = W_BASE;
      W_BASE: st_nxt = W_WALK;
      W_WALK: if (row_end) st_nxt = W_IDLE;
      default: st_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= W_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      W_IDLE: begin
        if (req.start) begin
          xt_r <= PW'(req.src_x) * PW'(TARGET_SIZE);
          xe_r <= (PW'(req.src_x) + PW'(req.rect_width)) * PW'(TARGET_SIZE);
          yt_r <= PW'(req.src_y) * PW'(TARGET_SIZE);
          ye_r <= (PW'(req.src_y) + PW'(req.rect_height)) * PW'(TARGET_SIZE);
        end
      end
      W_EST: begin
        cest_r <= CW'(px >> K);
        r_r    <= CW'(py >> K);
      end
      W_BASE: begin
        c_r   <= cest_r;
        cs0_r <= PW'(cest_r) * PW'(SOURCE_SIZE);
        cs_r  <= PW'(cest_r) * PW'(SOURCE_SIZE);
        rs_r  <= PW'(r_r) * PW'(SOURCE_SIZE);
        rb_r  <= RBW'(r_r) * RBW'(TARGET_SIZE);
      end
      W_WALK: begin
        if (!row_end) begin
          if (!row_in || col_end) begin
            r_r  <= r_r + CW'(1);
            rs_r <= rs_r + PW'(SOURCE_SIZE);
            rb_r <= rb_r + RBW'(TARGET_SIZE);
            c_r  <= cest_r;
            cs_r <= cs0_r;
          end else begin
            c_r  <= c_r + CW'(1);
            cs_r <= cs_r + PW'(SOURCE_SIZE);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st.busy  = (st_r != W_IDLE);
  assign st.wr_en = (st_r == W_WALK) && !row_end && row_in && !col_end && col_in;
  assign st.fin   = (st_r == W_WALK) && row_end;
  assign wr_addr  = AW'(rb_r + RBW'(c_r));

endmodule

`default_nettype wire

@@ rtl/core/png_rect_downscale_to_rgb565_core.sv @@
// Top level: event handler around the RGB565 frame store and the span walker.
// Item handling: header, end, rejected draws and out-of-range reads go straight to
//   the result state; an in-range read waits in ST_READ for the registered memory read;
//   a draw runs the span walker over the rectangle; a start runs the clearing pass first.
// Throughput: one item at a time; in_ready is high only in ST_IDLE, after the last result.
// Reset: flags clear, expected size back to 501x1002, then a clearing pass writes all
//   TARGET_SIZE^2 entries (16384 by default) to fill the store before any item is taken.
`default_nettype none

module png_rect_downscale_to_rgb565_core import pngds_pkg::*; #(
  parameter int SOURCE_SIZE = 500,
  parameter int TARGET_SIZE = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // event items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pngds_in_t   in_data,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output pngds_out_t       out_data
);

  localparam int DEPTH = TARGET_SIZE * TARGET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  // top-level sequencer
  localparam logic [2:0] ST_CLEAR = 3'd0;  // fill store with background
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an item
  localparam logic [2:0] ST_DRAW  = 3'd2;  // walker writing the rectangle
  localparam logic [2:0] ST_READ  = 3'd3;  // memory read in flight
  localparam logic [2:0] ST_RESP  = 3'd4;  // result ready for the out register

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_last;
  logic          reply_r;        // clear pass came from a start item
  logic          inv_r, done_r;
  logic [15:0]   exp_w_r, exp_h_r;
  logic [15:0]   color_r;        // draw color of the item in work
  logic [15:0]   res_color_r;
  logic          out_valid_r;
  pngds_out_t    out_data_r;

  logic            in_fire, draw_go, read_go, resp_load;
  pngds_walk_req_t walk_req;
  pngds_walk_st_t  walk_st;
  logic [AW-1:0]   walk_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign resp_load = (st_r == ST_RESP) && (!out_valid_r || out_ready);

  // A draw only walks when the image is valid and the corner is inside the source
  assign draw_go = in_fire && (in_data.func == FN_DRAW) && !inv_r &&
                   (in_data.src_x < SOURCE_SIZE) && (in_data.src_y < SOURCE_SIZE);
  assign read_go = in_fire && (in_data.func == FN_READ) && (in_data.read_address < DEPTH);

  assign walk_req.start       = draw_go;
  assign walk_req.src_x       = in_data.src_x;
  assign walk_req.src_y       = in_data.src_y;
  assign walk_req.rect_width  = in_data.rect_width;
  assign walk_req.rect_height = in_data.rect_height;

  pngds_walk #(
    .SOURCE_SIZE (SOURCE_SIZE),
    .TARGET_SIZE (TARGET_SIZE)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (walk_req),
    .st      (walk_st),
    .wr_addr (walk_addr)
  );

  // Write port: clearing pass owns it in ST_CLEAR, the walker in ST_DRAW
  assign ram_we    = (st_r == ST_CLEAR) || walk_st.wr_en;
  assign ram_waddr = (st_r == ST_CLEAR) ? clr_cnt_r : walk_addr;
  assign ram_wdata = (st_r == ST_CLEAR) ? BG_COLOR : color_r;

  pngds_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (read_go),
    .raddr (AW'(in_data.read_address)),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_last) st_nxt = reply_r ? ST_RESP : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.func)
            FN_START: st_nxt = ST_CLEAR;
            FN_DRAW:  st_nxt = draw_go ? ST_DRAW : ST_RESP;
            FN_READ:  st_nxt = read_go ? ST_READ : ST_RESP;
            default:  st_nxt = ST_RESP;
          endcase
        end
      end
      ST_DRAW: begin
        if (walk_st.fin) st_nxt = ST_RESP;
      end
      ST_READ: st_nxt = ST_RESP;
      ST_RESP: begin
        if (resp_load) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      reply_r     <= 1'b0;
      inv_r       <= 1'b0;
      done_r      <= 1'b0;
      exp_w_r     <= EXP_WIDTH_RST;
      exp_h_r     <= EXP_HEIGHT_RST;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXP_WIDTH:  exp_w_r <= cfg_wdata;
          CFG_EXP_HEIGHT: exp_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (st_r == ST_CLEAR) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if (in_fire) begin
        case (in_data.func)
          FN_START: begin
            inv_r   <= 1'b0;
            done_r  <= 1'b0;
            reply_r <= 1'b1;
          end
          FN_HEADER: inv_r <= (in_data.img_width != exp_w_r) ||
                              (in_data.img_height != exp_h_r);
          FN_END:    done_r <= 1'b1;
          default: begin
          end
        endcase
      end
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      color_r     <= (in_data.alpha == 8'd0) ? BG_COLOR :
                     {in_data.red[7:3], in_data.green[7:2], in_data.blue[7:3]};
      res_color_r <= 16'd0;
    end
    if (st_r == ST_READ) begin
      res_color_r <= ram_rdata;
    end
    if (resp_load) begin
      out_data_r.read_color    <= res_color_r;
      out_data_r.image_invalid <= inv_r;
      out_data_r.image_done    <= done_r && !inv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the walker never writes during the clearing pass
  a_no_walk_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !((st_r == ST_CLEAR) && walk_st.wr_en))
    else $error("walker write during clearing pass");

  // the walker runs only while the sequencer waits for it
  a_walk_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    walk_st.busy |-> (st_r == ST_DRAW))
    else $error("walker busy outside draw state");

  // an in-range read goes straight to the memory wait state
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    read_go |=> (st_r == ST_READ))
    else $error("read item did not wait for memory data");

  // done is never reported together with invalid
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.image_done && out_data_r.image_invalid))
    else $error("done reported on invalid image");

endmodule

`default_nettype wire
